// ===== hw/rtl/flk_pkg.sv =====
// ----------------------------------------------------------------------------
// flk_pkg: shared constants, types and helpers for the FIFO handoff lock unit
// Holds table sizes, field widths, mode and status codes, and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package flk_pkg;

  // Table sizes
  localparam int NUM_LOCKS   = 16;
  localparam int MAX_WAITERS = 16;
  localparam int ID_BITS     = 8;

  // Field widths fixed by the interface
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int CALLER_W = 8;
  localparam int STATUS_W = 3;
  localparam int OWNER_W  = 8;

  // Derived widths
  localparam int SLOT_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int COUNT_W = $clog2(MAX_WAITERS + 2);
  localparam int ADDR_W  = INDEX_W + SLOT_W;
  localparam int MEM_DEPTH = NUM_LOCKS * MAX_WAITERS;

  // Packed beat widths, rounded up to whole bytes
  localparam int IN_BITS  = MODE_W + INDEX_W + CALLER_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + 1 + OWNER_W + 1 + OWNER_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_REG    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIGNAL = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNREG   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input beat and launch the waiter read
    logic commit;   // update the entry and load the result register
  } flk_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free; // result register empty or draining this cycle
  } flk_sts_t;

  // Advance a circular queue slot
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    next_slot = (p == SLOT_W'(MAX_WAITERS - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/fifo_handoff_lock_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_handoff_lock_unit: indexed lock table with FIFO handoff to waiters
// Usage:
//   Requests arrive as beats on the in_ channel (register, wait, signal on
//   one of 16 lock entries); every request gives exactly one result beat on
//   the out_ channel with a status, the owner after the step and the waiter
//   woken by a signal, if any.
//   A request is first latched while the head waiter is read from the
//   waiter memory (registered read port); then the entry is updated and
//   the result register loaded. No new request is taken before it commits.
//   The result beat is valid once the request commits; the commit waits
//   while the result register holds a result that has not been taken.
//   When the receiver stalls, the finished result waits in the output
//   register; one further request is accepted and held ready to commit until
//   that result is taken, and the input channel then stalls.
//   Reset clears all entries to unregistered with no owner and empty
//   queues; no clearing pass is needed, as waiter memory data is only used
//   from slots that a wait has written.
// ----------------------------------------------------------------------------
module fifo_handoff_lock_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // mode [1:0], sem_index [5:2], caller_id [13:6], zero [15:14]
  input  logic [flk_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // status [2:0], owner_valid [3], owner_id [11:4], woken_valid [12],
  // woken_id [20:13], zero [23:21]
  output logic [flk_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready
);

  localparam int OWN_V_POS  = flk_pkg::STATUS_W;
  localparam int OWN_POS    = OWN_V_POS + 1;
  localparam int WAKE_V_POS = OWN_POS + flk_pkg::OWNER_W;
  localparam int WAKE_POS   = WAKE_V_POS + 1;
  localparam int IDX_POS    = flk_pkg::MODE_W;
  localparam int CALL_POS   = IDX_POS + flk_pkg::INDEX_W;

  flk_pkg::flk_cmd_t              cmd;
  flk_pkg::flk_sts_t              sts;
  logic [flk_pkg::STATUS_W-1:0]   res_status;
  logic                           res_own_v;
  logic [flk_pkg::OWNER_W-1:0]    res_own;
  logic                           res_wake_v;
  logic [flk_pkg::OWNER_W-1:0]    res_wake;

  flk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  flk_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_tdata[IDX_POS-1:0]),
    .in_sem_index    (in_tdata[CALL_POS-1:IDX_POS]),
    .in_caller_id    (in_tdata[CALL_POS+flk_pkg::CALLER_W-1:CALL_POS]),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_status      (res_status),
    .out_owner_valid (res_own_v),
    .out_owner_id    (res_own),
    .out_woken_valid (res_wake_v),
    .out_woken_id    (res_wake)
  );

  // Pack the result beat, zero-filled to whole bytes
  always_comb begin
    out_tdata = '0;
    out_tdata[flk_pkg::STATUS_W-1:0]                 = res_status;
    out_tdata[OWN_V_POS]                             = res_own_v;
    out_tdata[OWN_POS+flk_pkg::OWNER_W-1:OWN_POS]    = res_own;
    out_tdata[WAKE_V_POS]                            = res_wake_v;
    out_tdata[WAKE_POS+flk_pkg::OWNER_W-1:WAKE_POS]  = res_wake;
  end

endmodule

// ===== hw/rtl/flk_ctrl.sv =====
// ----------------------------------------------------------------------------
// flk_ctrl: request sequencer for the FIFO handoff lock unit
// Takes one request beat, waits in the execute state for the waiter memory
// read, then commits once the result register can take the result.
// ----------------------------------------------------------------------------
module flk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  flk_pkg::flk_sts_t sts,
  output flk_pkg::flk_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // Accept only between requests
  assign in_tready   = (state_r == S_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.commit  = (state_r == S_EXEC) && sts.out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/flk_dpath.sv =====
// ----------------------------------------------------------------------------
// flk_dpath: entry table, waiter memory and result register
// Keeps per-entry in-use bit, count, owner and queue pointers in flops and
// the waiter ids in a memory with a registered read port.
// ----------------------------------------------------------------------------
module flk_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  flk_pkg::flk_cmd_t                 cmd,
  output flk_pkg::flk_sts_t                 sts,
  input  logic [flk_pkg::MODE_W-1:0]        in_mode,
  input  logic [flk_pkg::INDEX_W-1:0]       in_sem_index,
  input  logic [flk_pkg::CALLER_W-1:0]      in_caller_id,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [flk_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_owner_valid,
  output logic [flk_pkg::OWNER_W-1:0]       out_owner_id,
  output logic                              out_woken_valid,
  output logic [flk_pkg::OWNER_W-1:0]       out_woken_id
);

  // Entry table
  logic [flk_pkg::NUM_LOCKS-1:0] use_r;
  logic [flk_pkg::COUNT_W-1:0]   cnt_r   [flk_pkg::NUM_LOCKS];
  logic [flk_pkg::ID_BITS-1:0]   own_r   [flk_pkg::NUM_LOCKS];
  logic [flk_pkg::SLOT_W-1:0]    head_r  [flk_pkg::NUM_LOCKS];
  logic [flk_pkg::SLOT_W-1:0]    tail_r  [flk_pkg::NUM_LOCKS];

  // Waiter memory
  logic [flk_pkg::ID_BITS-1:0]   wait_mem [flk_pkg::MEM_DEPTH];
  logic [flk_pkg::ID_BITS-1:0]   rd_data_r;

  // Latched request
  logic [flk_pkg::MODE_W-1:0]    mode_r;
  logic [flk_pkg::INDEX_W-1:0]   idx_r;
  logic [flk_pkg::ID_BITS-1:0]   caller_r;

  // Result register
  logic                          out_valid_r;
  logic [flk_pkg::STATUS_W-1:0]  res_status_r;
  logic                          res_own_v_r;
  logic [flk_pkg::OWNER_W-1:0]   res_own_r;
  logic                          res_wake_v_r;
  logic [flk_pkg::OWNER_W-1:0]   res_wake_r;

  // Step results
  logic                          in_range;
  logic                          use_cur;
  logic [flk_pkg::COUNT_W-1:0]   cnt_cur;
  logic                          use_nxt;
  logic [flk_pkg::COUNT_W-1:0]   cnt_nxt;
  logic [flk_pkg::ID_BITS-1:0]   own_nxt;
  logic [flk_pkg::SLOT_W-1:0]    head_nxt;
  logic [flk_pkg::SLOT_W-1:0]    tail_nxt;
  logic [flk_pkg::STATUS_W-1:0]  status_nxt;
  logic                          wake_v_nxt;
  logic [flk_pkg::ID_BITS-1:0]   wake_nxt;
  logic                          enq;
  logic [flk_pkg::ADDR_W-1:0]    rd_addr;
  logic [flk_pkg::ADDR_W-1:0]    wr_addr;

  assign sts.out_free = !out_valid_r || out_tready;

  // Read the head waiter of the addressed entry as the beat arrives
  assign rd_addr = {in_sem_index, head_r[in_sem_index]};
  assign wr_addr = {idx_r, tail_r[idx_r]};

  // Compute the step for the latched request
  always_comb begin
    in_range   = (32'(idx_r) < flk_pkg::NUM_LOCKS);
    use_cur    = use_r[idx_r];
    cnt_cur    = cnt_r[idx_r];
    use_nxt    = use_cur;
    cnt_nxt    = cnt_cur;
    own_nxt    = own_r[idx_r];
    head_nxt   = head_r[idx_r];
    tail_nxt   = tail_r[idx_r];
    status_nxt = flk_pkg::ST_OK;
    wake_v_nxt = 1'b0;
    wake_nxt   = '0;
    enq        = 1'b0;
    if (!in_range) begin
      status_nxt = flk_pkg::ST_UNREG;
    end else begin
      case (mode_r)
        flk_pkg::MODE_REG: begin
          if (!use_cur) begin
            use_nxt  = 1'b1;
            cnt_nxt  = '0;
            own_nxt  = '0;
            head_nxt = '0;
            tail_nxt = '0;
          end
        end
        flk_pkg::MODE_WAIT: begin
          if (!use_cur) begin
            status_nxt = flk_pkg::ST_UNREG;
          end else if (cnt_cur == '0) begin
            cnt_nxt = flk_pkg::COUNT_W'(1);
            own_nxt = caller_r;
          end else if (cnt_cur >= flk_pkg::COUNT_W'(flk_pkg::MAX_WAITERS + 1)) begin
            status_nxt = flk_pkg::ST_FULL;
          end else begin
            enq        = 1'b1;
            tail_nxt   = flk_pkg::next_slot(tail_r[idx_r]);
            cnt_nxt    = cnt_cur + flk_pkg::COUNT_W'(1);
            status_nxt = flk_pkg::ST_BLOCKED;
          end
        end
        flk_pkg::MODE_SIGNAL: begin
          if (!use_cur) begin
            status_nxt = flk_pkg::ST_UNREG;
          end else if (cnt_cur == '0) begin
            status_nxt = flk_pkg::ST_UNDER;
          end else begin
            cnt_nxt = cnt_cur - flk_pkg::COUNT_W'(1);
            if (cnt_cur > flk_pkg::COUNT_W'(1)) begin
              // hand ownership to the oldest waiter
              wake_v_nxt = 1'b1;
              wake_nxt   = rd_data_r;
              own_nxt    = rd_data_r;
              head_nxt   = flk_pkg::next_slot(head_r[idx_r]);
            end else begin
              own_nxt = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      idx_r    <= in_sem_index;
      caller_r <= flk_pkg::ID_BITS'(in_caller_id);
    end
  end

  // Waiter memory: write on enqueue, registered read on capture
  always_ff @(posedge clk) begin
    if (cmd.commit && enq) begin
      wait_mem[wr_addr] <= caller_r;
    end
    if (cmd.capture) begin
      rd_data_r <= wait_mem[rd_addr];
    end
  end

  // Entry table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= '0;
      for (int i = 0; i < flk_pkg::NUM_LOCKS; i++) begin
        cnt_r[i]  <= '0;
        own_r[i]  <= '0;
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (cmd.commit && in_range) begin
      use_r[idx_r]  <= use_nxt;
      cnt_r[idx_r]  <= cnt_nxt;
      own_r[idx_r]  <= own_nxt;
      head_r[idx_r] <= head_nxt;
      tail_r[idx_r] <= tail_nxt;
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r <= status_nxt;
      res_own_v_r  <= in_range && use_nxt && (cnt_nxt != '0);
      res_own_r    <= (in_range && use_nxt && (cnt_nxt != '0))
                      ? flk_pkg::OWNER_W'(own_nxt) : '0;
      res_wake_v_r <= wake_v_nxt;
      res_wake_r   <= flk_pkg::OWNER_W'(wake_nxt);
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_status      = res_status_r;
  assign out_owner_valid = res_own_v_r;
  assign out_owner_id    = res_own_r;
  assign out_woken_valid = res_wake_v_r;
  assign out_woken_id    = res_wake_r;

  // A commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");

  // Capture and commit never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

  // A woken waiter becomes the owner shown in the same result
  a_wake_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && wake_v_nxt |=> out_owner_valid && (out_owner_id == out_woken_id)
      && (out_status == flk_pkg::ST_OK))
    else $error("woken waiter not reported as owner");

  // A blocked caller always leaves the entry owned
  a_blocked_owned: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (status_nxt == flk_pkg::ST_BLOCKED) |=> out_owner_valid)
    else $error("blocked caller on an entry without owner");

  // Count stays within holder plus a full queue
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (cnt_nxt <= flk_pkg::COUNT_W'(flk_pkg::MAX_WAITERS + 1)))
    else $error("entry count beyond queue capacity");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the FIFO handoff lock unit
// Drives register, wait and signal requests over the in_ stream and checks
// every out_ beat against a cycle-free model of the lock table or a typed script
// result. A short scripted part covers errors, a full wait queue and handoff.
// Random bursts then fill and drain single entries under varying backpressure.
// ----------------------------------------------------------------------------
module testbench;

  // Mode code the block ignores
  localparam logic [flk_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 7;
  localparam int DRAIN_CYCLES  = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 234;
  localparam int REPORT_MAX    = 10;
  localparam int SCRIPT_LEN    = 26;

  typedef struct packed {
    logic [flk_pkg::STATUS_W-1:0] status;
    logic                         owner_v;
    logic [flk_pkg::OWNER_W-1:0]  owner_id;
    logic                         woken_v;
    logic [flk_pkg::OWNER_W-1:0]  woken_id;
  } lock_result_t;

  typedef struct packed {
    logic [flk_pkg::MODE_W-1:0]   mode;
    logic [flk_pkg::INDEX_W-1:0]  idx;
    logic [flk_pkg::CALLER_W-1:0] caller;
    logic                         typed;
    lock_result_t                 res;
  } script_row_t;

  localparam lock_result_t NO_RES = '0;

  // Scripted requests; typed rows carry a result readable at a glance
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // wait, signal and ignored mode on an entry never registered
    '{flk_pkg::MODE_WAIT,   4'd3,  8'h00, 1'b1,
      '{flk_pkg::ST_UNREG, 1'b0, 8'h00, 1'b0, 8'h00}},
    '{flk_pkg::MODE_SIGNAL, 4'd3,  8'hff, 1'b1,
      '{flk_pkg::ST_UNREG, 1'b0, 8'h00, 1'b0, 8'h00}},
    '{MODE_NONE,            4'd3,  8'hff, 1'b1,
      '{flk_pkg::ST_OK,    1'b0, 8'h00, 1'b0, 8'h00}},
    // open the top entry, open it again, release it with nobody holding
    '{flk_pkg::MODE_REG,    4'd15, 8'h00, 1'b1,
      '{flk_pkg::ST_OK,    1'b0, 8'h00, 1'b0, 8'h00}},
    '{flk_pkg::MODE_REG,    4'd15, 8'hff, 1'b1,
      '{flk_pkg::ST_OK,    1'b0, 8'h00, 1'b0, 8'h00}},
    '{flk_pkg::MODE_SIGNAL, 4'd15, 8'h00, 1'b1,
      '{flk_pkg::ST_UNDER, 1'b0, 8'h00, 1'b0, 8'h00}},
    // grant, then the owner itself queues behind its own lock
    '{flk_pkg::MODE_WAIT,   4'd15, 8'hff, 1'b1,
      '{flk_pkg::ST_OK,      1'b1, 8'hff, 1'b0, 8'h00}},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'hff, 1'b1,
      '{flk_pkg::ST_BLOCKED, 1'b1, 8'hff, 1'b0, 8'h00}},
    // fill the wait queue
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h00, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h01, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h02, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h04, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h08, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h10, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h20, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h40, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h80, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h55, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'haa, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h0f, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'hf0, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h3c, 1'b0, NO_RES},
    '{flk_pkg::MODE_WAIT,   4'd15, 8'hc3, 1'b0, NO_RES},
    // queue full, then hand off to the oldest waiter, then ignored mode
    '{flk_pkg::MODE_WAIT,   4'd15, 8'h99, 1'b1,
      '{flk_pkg::ST_FULL, 1'b1, 8'hff, 1'b0, 8'h00}},
    '{flk_pkg::MODE_SIGNAL, 4'd15, 8'h00, 1'b1,
      '{flk_pkg::ST_OK,   1'b1, 8'hff, 1'b1, 8'hff}},
    '{MODE_NONE,            4'd15, 8'h00, 1'b1,
      '{flk_pkg::ST_OK,   1'b1, 8'hff, 1'b0, 8'h00}}
  };

  logic                         clk;
  logic                         rst_n;
  logic [flk_pkg::IN_W-1:0]     in_tdata;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [flk_pkg::OUT_W-1:0]    out_tdata;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;

  // Lock table mirror
  logic                         lock_in_use [flk_pkg::NUM_LOCKS];
  logic [4:0]                   lock_count  [flk_pkg::NUM_LOCKS];
  logic [flk_pkg::OWNER_W-1:0]  lock_owner  [flk_pkg::NUM_LOCKS];
  logic [flk_pkg::OWNER_W-1:0]  lock_waiter [flk_pkg::NUM_LOCKS][flk_pkg::MAX_WAITERS];
  logic [3:0]                   wq_head     [flk_pkg::NUM_LOCKS];
  logic [3:0]                   wq_tail     [flk_pkg::NUM_LOCKS];

  lock_result_t        pending_results [$];

  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  err_count;
  int                  stall_cycles = 0;
  int                  req_count;
  int                  blocked_seen;
  int                  full_seen;
  int                  under_seen;
  int                  unreg_seen;
  int                  handoff_seen;

  fifo_handoff_lock_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one request to the mirror and return the result beat it gives
  function automatic lock_result_t apply_request(
      input logic [flk_pkg::MODE_W-1:0]   mode,
      input logic [flk_pkg::INDEX_W-1:0]  idx,
      input logic [flk_pkg::CALLER_W-1:0] caller);
    lock_result_t r;
    r = '0;
    r.status = flk_pkg::ST_OK;
    case (mode)
      flk_pkg::MODE_REG: begin
        if (!lock_in_use[idx]) begin
          lock_in_use[idx] = 1'b1;
          lock_count[idx]  = '0;
          lock_owner[idx]  = '0;
          wq_head[idx]     = '0;
          wq_tail[idx]     = '0;
        end
      end
      flk_pkg::MODE_WAIT: begin
        if (!lock_in_use[idx]) begin
          r.status = flk_pkg::ST_UNREG;
        end else if (lock_count[idx] == 0) begin
          lock_count[idx] = 5'd1;
          lock_owner[idx] = caller;
        end else if (int'(lock_count[idx]) - 1 >= flk_pkg::MAX_WAITERS) begin
          r.status = flk_pkg::ST_FULL;
        end else begin
          lock_waiter[idx][wq_tail[idx]] = caller;
          wq_tail[idx] = (int'(wq_tail[idx]) == flk_pkg::MAX_WAITERS - 1)
                         ? 4'd0 : wq_tail[idx] + 4'd1;
          lock_count[idx] = lock_count[idx] + 5'd1;
          r.status = flk_pkg::ST_BLOCKED;
        end
      end
      flk_pkg::MODE_SIGNAL: begin
        if (!lock_in_use[idx]) begin
          r.status = flk_pkg::ST_UNREG;
        end else if (lock_count[idx] == 0) begin
          r.status = flk_pkg::ST_UNDER;
        end else begin
          lock_count[idx] = lock_count[idx] - 5'd1;
          if (lock_count[idx] != 0) begin
            r.woken_v  = 1'b1;
            r.woken_id = lock_waiter[idx][wq_head[idx]];
            wq_head[idx] = (int'(wq_head[idx]) == flk_pkg::MAX_WAITERS - 1)
                           ? 4'd0 : wq_head[idx] + 4'd1;
            lock_owner[idx] = r.woken_id;
          end else begin
            lock_owner[idx] = '0;
          end
        end
      end
      default: ;
    endcase
    if (lock_in_use[idx] && lock_count[idx] != 0) begin
      r.owner_v  = 1'b1;
      r.owner_id = lock_owner[idx];
    end
    return r;
  endfunction

  // Present one request beat, hold it until taken, then queue its result
  task automatic send_request(input logic [flk_pkg::MODE_W-1:0]   mode,
                              input logic [flk_pkg::INDEX_W-1:0]  idx,
                              input logic [flk_pkg::CALLER_W-1:0] caller,
                              input logic                         typed,
                              input lock_result_t                 typed_res);
    lock_result_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= flk_pkg::IN_W'({caller, idx, mode});
    do @(posedge clk); while (!in_tready);
    r = apply_request(mode, idx, caller);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    req_count++;
    case (r.status)
      flk_pkg::ST_BLOCKED: blocked_seen++;
      flk_pkg::ST_FULL:    full_seen++;
      flk_pkg::ST_UNDER:   under_seen++;
      flk_pkg::ST_UNREG:   unreg_seen++;
      default: ;
    endcase
    if (r.woken_v) handoff_seen++;
  endtask

  // Hold the input idle until every queued result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random bursts: most work one entry to fill, drain or churn its queue
  task automatic run_random(input int target);
    int                           sent;
    int                           kind;
    int                           len;
    logic [flk_pkg::INDEX_W-1:0]  idx;
    logic [flk_pkg::MODE_W-1:0]   mode;
    logic [flk_pkg::CALLER_W-1:0] caller;
    sent = 0;
    while (sent < target) begin
      idx  = flk_pkg::INDEX_W'($urandom_range(flk_pkg::NUM_LOCKS - 1));
      kind = $urandom_range(9);
      len  = $urandom_range(1, 24);
      // open the entry first in most well-formed bursts
      if (kind != 0 && !lock_in_use[idx] && $urandom_range(9) < 8) begin
        send_request(flk_pkg::MODE_REG, idx, flk_pkg::CALLER_W'($urandom), 1'b0, NO_RES);
        sent++;
      end
      repeat (len) begin
        caller = flk_pkg::CALLER_W'($urandom);
        if (kind == 0) begin
          mode = flk_pkg::MODE_W'($urandom);
          idx  = flk_pkg::INDEX_W'($urandom);
        end else if (kind <= 3) begin
          mode = ($urandom_range(99) < 85) ? flk_pkg::MODE_WAIT : flk_pkg::MODE_SIGNAL;
        end else if (kind <= 6) begin
          mode = ($urandom_range(99) < 85) ? flk_pkg::MODE_SIGNAL : flk_pkg::MODE_WAIT;
        end else begin
          mode = $urandom_range(1) ? flk_pkg::MODE_WAIT : flk_pkg::MODE_SIGNAL;
        end
        send_request(mode, idx, caller, 1'b0, NO_RES);
        if (mode != MODE_NONE) sent++;
      end
    end
  endtask

  // Randomize result backpressure every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each result beat against the oldest pending result
  always @(posedge clk) begin
    lock_result_t got;
    lock_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = out_tdata[2:0];
      got.owner_v  = out_tdata[3];
      got.owner_id = out_tdata[11:4];
      got.woken_v  = out_tdata[12];
      got.woken_id = out_tdata[20:13];
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("unexpected result beat: status %0d owner %0d/%0h woken %0d/%0h",
                   got.status, got.owner_v, got.owner_id, got.woken_v, got.woken_id);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.owner_v !== want.owner_v ||
            got.owner_id !== want.owner_id || got.woken_v !== want.woken_v ||
            got.woken_id !== want.woken_id) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display({"mismatch: exp status %0d owner %0d/%0h woken %0d/%0h,",
                      " got status %0d owner %0d/%0h woken %0d/%0h"},
                     want.status, want.owner_v, want.owner_id, want.woken_v,
                     want.woken_id, got.status, got.owner_v, got.owner_id,
                     got.woken_v, got.woken_id);
        end
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    send_idle_pct = 23;
    recv_idle_pct = 66;
    err_count     = 0;
    req_count     = 0;
    blocked_seen  = 0;
    full_seen     = 0;
    under_seen    = 0;
    unreg_seen    = 0;
    handoff_seen  = 0;
    for (int i = 0; i < flk_pkg::NUM_LOCKS; i++) begin
      lock_in_use[i] = 1'b0;
      lock_count[i]  = '0;
      lock_owner[i]  = '0;
      wq_head[i]     = '0;
      wq_tail[i]     = '0;
      for (int j = 0; j < flk_pkg::MAX_WAITERS; j++) lock_waiter[i][j] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // scripted part
    for (int i = 0; i < SCRIPT_LEN; i++)
      send_request(SCRIPT[i].mode, SCRIPT[i].idx, SCRIPT[i].caller,
                   SCRIPT[i].typed, SCRIPT[i].res);
    drain_results();

    // random part: sender light and receiver heavy idling, then swapped, then none
    run_random(PHASE_ITEMS);
    drain_results();
    send_idle_pct = 66;
    recv_idle_pct = 23;
    run_random(PHASE_ITEMS);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d requests: %0d blocked, %0d queue full, %0d underflow,",
             req_count, blocked_seen, full_seen, under_seen);
    $display("%0d unregistered, %0d handoffs to waiters, %0d mismatches",
             unreg_seen, handoff_seen, err_count);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
